// ----- sv/mwsg_pkg.sv -----
// Package for the multi-waveform sample generator: waveform codes, sample
// constants and the elaboration-time builders for the sine and tangent tables.
// No dependencies.
package mwsg_pkg;

   localparam int PHASE_BITS_DEF = 16;
   localparam int TABLE_BITS_DEF = 10;

   localparam int PHASE_W  = 16;
   localparam int MODE_W   = 3;
   localparam int SAMPLE_W = 16;

   localparam logic [MODE_W-1:0] MODE_SINE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SQUARE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TRI    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SAW    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TAN    = 3'd4;

   localparam logic signed [SAMPLE_W-1:0] ONE_Q14     = 16'sd16384;
   localparam logic signed [SAMPLE_W-1:0] NEG_ONE_Q14 = -16'sd16384;

   localparam longint unsigned Q30_ONE    = 64'd1 << 30;
   localparam longint unsigned PI_Q30     = 64'd3373259426;
   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

   typedef struct packed {
      longint s;
      longint c;
   } sincos_type;

   // Restoring long division, divisor below 2^63
   function automatic longint unsigned udiv64(input longint unsigned a,
                                              input longint unsigned b);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], a[i]};
         if (r >= b) begin
            r    = r - b;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Eleven-term Taylor series in Q30, 0 <= x <= about pi/2
   function automatic sincos_type sin_cos_q30(input longint unsigned x);
      longint unsigned ts;
      longint unsigned tc;
      longint unsigned dv_s;
      longint unsigned dv_c;
      sincos_type      r;
      ts  = x;
      tc  = Q30_ONE;
      r.s = longint'(x);
      r.c = longint'(Q30_ONE);
      for (int n = 1; n <= 10; n++) begin
         dv_s = longint'((2 * n) * (2 * n + 1));
         dv_c = longint'((2 * n - 1) * (2 * n));
         ts = udiv64((((ts * x) >> 30) * x) >> 30, dv_s);
         tc = udiv64((((tc * x) >> 30) * x) >> 30, dv_c);
         if ((n & 1) == 1) begin
            r.s = r.s - longint'(ts);
            r.c = r.c - longint'(tc);
         end else begin
            r.s = r.s + longint'(ts);
            r.c = r.c + longint'(tc);
         end
      end
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] q30_to_q14(input longint v);
      longint unsigned u;
      if (v <= 0) begin
         return '0;
      end
      u = (longint'(v) + (64'd1 << 15)) >> 16;
      return SAMPLE_W'(u);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sine_quadrant(
      input longint unsigned m, input int tb);
      longint unsigned x;
      sincos_type      sc;
      x  = (m * TWO_PI_Q30 + (64'd1 << (tb - 1))) >> tb;
      sc = sin_cos_q30(x);
      return q30_to_q14(sc.s);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sine_entry(
      input longint unsigned k, input int tb);
      longint unsigned              quarter;
      longint unsigned              qd;
      longint unsigned              j;
      logic signed [SAMPLE_W-1:0]   v;
      quarter = 64'd1 << (tb - 2);
      qd      = (k >> (tb - 2)) & 64'd3;
      j       = k & (quarter - 64'd1);
      v = (qd[0]) ? sine_quadrant(quarter - j, tb) : sine_quadrant(j, tb);
      return (qd[1]) ? -v : v;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] tan_half(
      input longint unsigned k, input int tb);
      longint unsigned x;
      longint unsigned den;
      longint unsigned us;
      longint unsigned q;
      sincos_type      sc;
      x  = (k * PI_Q30 + (64'd1 << (tb - 1))) >> tb;
      sc = sin_cos_q30(x);
      if (sc.c <= 0) begin
         return ONE_Q14;
      end
      us  = (sc.s < 0) ? 64'd0 : longint'(sc.s);
      den = (longint'(sc.c) * TWO_PI_Q30) >> 30;
      if (den == 0 || us >= den) begin
         return ONE_Q14;
      end
      q = udiv64((us << 15) + den, den << 1);
      return SAMPLE_W'(q);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] tan_entry(
      input longint unsigned k, input int tb);
      longint unsigned half;
      longint unsigned n;
      half = 64'd1 << (tb - 1);
      n    = 64'd1 << tb;
      if (k == half) begin
         return ONE_Q14;
      end
      if (k < half) begin
         return tan_half(k, tb);
      end
      return -tan_half(n - k, tb);
   endfunction

endpackage

// ----- sv/mwsg_table_rom.sv -----
// Synchronous ROM holding the sine table (lower half) and the tangent
// table (upper half), one registered read port. Depends on mwsg_pkg.
module mwsg_table_rom #(
   parameter int TABLE_BITS = mwsg_pkg::TABLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic [TABLE_BITS:0]                  rd_addr,
   output logic signed [mwsg_pkg::SAMPLE_W-1:0] rd_data
);
   import mwsg_pkg::*;

   localparam int N     = 2 ** TABLE_BITS;
   localparam int DEPTH = 2 * N;

   logic signed [SAMPLE_W-1:0] rom_w [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      localparam logic signed [SAMPLE_W-1:0] ENTRY = (i < N) ?
         sine_entry(longint'(i), TABLE_BITS) : tan_entry(longint'(i - N), TABLE_BITS);
      assign rom_w[i] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_w[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/mwsg_shape_calc.sv -----
// Square, triangle and sawtooth samples computed from the phase bits;
// zero for the table and unused selectors. Depends on mwsg_pkg.
module mwsg_shape_calc #(
   parameter int PHASE_BITS = mwsg_pkg::PHASE_BITS_DEF
) (
   input  logic [PHASE_BITS-1:0]                phase,
   input  logic [mwsg_pkg::MODE_W-1:0]          mode,
   output logic signed [mwsg_pkg::SAMPLE_W-1:0] sample
);
   import mwsg_pkg::*;

   localparam int FR_W  = PHASE_BITS - 2;
   localparam int TRI_W = PHASE_BITS + 13;
   localparam int SAW_W = PHASE_BITS + 16;

   logic [1:0]          qd;
   logic [TRI_W-1:0]    tri_sum;
   logic [14:0]         f;
   logic signed [16:0]  f_s;
   logic signed [16:0]  tri_val;
   logic [SAW_W-1:0]    saw_sum;
   logic signed [16:0]  saw_val;

   assign qd      = phase[PHASE_BITS-1 -: 2];
   assign tri_sum = {1'b0, phase[FR_W-1:0], 14'b0} + (TRI_W'(1) << (PHASE_BITS - 3));
   assign f       = tri_sum[TRI_W-1 -: 15];
   assign f_s     = {2'b00, f};

   always_comb begin
      case (qd)
         2'd0:    tri_val = f_s;
         2'd1:    tri_val = 17'sd16384 - f_s;
         2'd2:    tri_val = -f_s;
         default: tri_val = f_s - 17'sd16384;
      endcase
   end

   assign saw_sum = {1'b0, phase, 15'b0} + (SAW_W'(1) << (PHASE_BITS - 1));
   assign saw_val = $signed({1'b0, saw_sum[SAW_W-1 -: 16]}) - 17'sd16384;

   always_comb begin
      unique case (mode)
         MODE_SQUARE: sample = phase[PHASE_BITS-1] ? NEG_ONE_Q14 : ONE_Q14;
         MODE_TRI:    sample = tri_val[SAMPLE_W-1:0];
         MODE_SAW:    sample = saw_val[SAMPLE_W-1:0];
         default:     sample = '0;
      endcase
   end

endmodule

// ----- sv/multi_waveform_sample_generator_core.sv -----
// Multi-waveform sample generator top level: one sample per transaction.
// A req transaction passes the registered read of the table ROM and then the
// output register before rsp_tvalid; a stall at the output can hold it between.
// Throughput: one transaction per cycle; req_tready stays high while the
// output side takes results. Reset clears the valid flags only; the tables
// are constant and need no clearing pass. Depends on mwsg_pkg and submodules.
module multi_waveform_sample_generator_core #(
   parameter int PHASE_BITS = mwsg_pkg::PHASE_BITS_DEF,
   parameter int TABLE_BITS = mwsg_pkg::TABLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] phase
   input  logic [2:0]  req_tuser,   // [2:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] sample
);
   import mwsg_pkg::*;

   logic [PHASE_BITS-1:0]       phase;
   logic [TABLE_BITS-1:0]       tbl_idx;
   logic [MODE_W-1:0]           mode;
   logic                        accept;
   logic                        s1_go;
   logic signed [SAMPLE_W-1:0]  calc;
   logic signed [SAMPLE_W-1:0]  rom_q;

   logic                        s1_vld_ff, s1_vld_in;
   logic [MODE_W-1:0]           mode_ff;
   logic signed [SAMPLE_W-1:0]  calc_ff;
   logic                        out_vld_ff, out_vld_in;
   logic signed [SAMPLE_W-1:0]  sample_ff, sample_in;

   assign mode = req_tuser;

   if (PHASE_BITS <= PHASE_W) begin : g_narrow
      assign phase = req_tdata[PHASE_BITS-1:0];
   end else begin : g_wide
      assign phase = {{(PHASE_BITS - PHASE_W){1'b0}}, req_tdata};
   end

   if (PHASE_BITS >= TABLE_BITS) begin : g_idx_top
      assign tbl_idx = phase[PHASE_BITS-1 -: TABLE_BITS];
   end else begin : g_idx_pad
      assign tbl_idx = {phase, {(TABLE_BITS - PHASE_BITS){1'b0}}};
   end

   assign s1_go      = s1_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !s1_vld_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   mwsg_table_rom #(
      .TABLE_BITS(TABLE_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr ({mode == MODE_TAN, tbl_idx}),
      .rd_data (rom_q)
   );

   mwsg_shape_calc #(
      .PHASE_BITS(PHASE_BITS)
   ) u_shape (
      .phase  (phase),
      .mode   (mode),
      .sample (calc)
   );

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (s1_go) begin
         s1_vld_in = 1'b0;
      end

      out_vld_in = out_vld_ff;
      if (s1_go) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end

      if (mode_ff == MODE_SINE || mode_ff == MODE_TAN) begin
         sample_in = rom_q;
      end else begin
         sample_in = calc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= mode;
         calc_ff <= calc;
      end
      if (s1_go) begin
         sample_ff <= sample_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = sample_ff;

endmodule

// ----- bench/multi_waveform_sample_generator_core_tb.sv -----
// Self-checking bench for multi_waveform_sample_generator_core: directed and random
// phase/mode transactions, checked against an in-bench waveform predictor.
// Depends on mwsg_pkg and the core RTL.
module multi_waveform_sample_generator_core_tb;
   import mwsg_pkg::*;

   localparam int PB = PHASE_BITS_DEF;
   localparam int TB = TABLE_BITS_DEF;

   localparam longint unsigned Q30_UNIT  = 64'd1 << 30;
   localparam longint unsigned PI_Q30_C  = 64'd3373259426;
   localparam longint unsigned TAU_Q30_C = 64'd6746518852;
   localparam int              FULL_Q14  = 16384;

   localparam logic [MODE_W-1:0] MODE_NULL5 = 3'd5;
   localparam logic [MODE_W-1:0] MODE_NULL6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_NULL7 = 3'd7;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [PHASE_W-1:0]  req_tdata;   // [15:0] phase
   logic [MODE_W-1:0]   req_tuser;   // [2:0] mode
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [SAMPLE_W-1:0] rsp_tdata;   // [15:0] sample

   logic signed [SAMPLE_W-1:0] pending_samples[$];
   logic signed [SAMPLE_W-1:0] want_sample;
   int                         fail_count = 0;
   bit                         idle_enable = 1'b1;

   multi_waveform_sample_generator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // sin and cos in Q30, eleven-term series
   function automatic void series_sin_cos(input longint unsigned ang, output longint s_out,
                                          output longint c_out);
      longint unsigned term_s;
      longint unsigned term_c;
      longint unsigned div_s;
      longint unsigned div_c;
      term_s = ang;
      term_c = Q30_UNIT;
      s_out  = longint'(ang);
      c_out  = longint'(Q30_UNIT);
      for (int i = 1; i <= 10; i++) begin
         div_s  = longint'((2 * i) * (2 * i + 1));
         div_c  = longint'((2 * i - 1) * (2 * i));
         term_s = ((((term_s * ang) >> 30) * ang) >> 30) / div_s;
         term_c = ((((term_c * ang) >> 30) * ang) >> 30) / div_c;
         if (i % 2 == 1) begin
            s_out = s_out - longint'(term_s);
            c_out = c_out - longint'(term_c);
         end else begin
            s_out = s_out + longint'(term_s);
            c_out = c_out + longint'(term_c);
         end
      end
   endfunction

   function automatic int sine_lookup(input longint unsigned k);
      longint unsigned quarter;
      longint unsigned quad;
      longint unsigned m;
      longint unsigned ang;
      longint          s_v;
      longint          c_v;
      int              v;
      quarter = 64'd1 << (TB - 2);
      quad    = (k >> (TB - 2)) & 64'd3;
      m       = k & (quarter - 64'd1);
      if (quad[0])
         m = quarter - m;
      ang = (m * TAU_Q30_C + (64'd1 << (TB - 1))) >> TB;
      series_sin_cos(ang, s_v, c_v);
      v = (s_v <= 0) ? 0 : int'((longint'(s_v) + 64'sd32768) >>> 16);
      return quad[1] ? -v : v;
   endfunction

   function automatic int tangent_half(input longint unsigned k);
      longint unsigned ang;
      longint unsigned num;
      longint unsigned den;
      longint          s_v;
      longint          c_v;
      ang = (k * PI_Q30_C + (64'd1 << (TB - 1))) >> TB;
      series_sin_cos(ang, s_v, c_v);
      if (c_v <= 0)
         return FULL_Q14;
      num = (s_v < 0) ? 64'd0 : longint'(s_v);
      den = (longint'(c_v) * TAU_Q30_C) >> 30;
      if (den == 0 || num >= den)
         return FULL_Q14;
      return int'(((num << 15) + den) / (den << 1));
   endfunction

   function automatic int tangent_lookup(input longint unsigned k);
      longint unsigned half;
      half = 64'd1 << (TB - 1);
      if (k == half)
         return FULL_Q14;
      if (k < half)
         return tangent_half(k);
      return -tangent_half((64'd1 << TB) - k);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] predict_sample(
      input logic [PHASE_W-1:0] ph, input logic [MODE_W-1:0] md);
      longint unsigned p;
      longint unsigned k;
      longint unsigned quad;
      longint unsigned fr;
      int              f;
      int              v;
      p = longint'(ph) & ((64'd1 << PB) - 64'd1);
      k = p >> (PB - TB);
      case (md)
         MODE_SINE: begin
            v = sine_lookup(k);
         end
         MODE_SQUARE: begin
            v = (p < (64'd1 << (PB - 1))) ? FULL_Q14 : -FULL_Q14;
         end
         MODE_TRI: begin
            quad = (p >> (PB - 2)) & 64'd3;
            fr   = p & ((64'd1 << (PB - 2)) - 64'd1);
            f    = int'(((fr << 14) + (64'd1 << (PB - 3))) >> (PB - 2));
            case (quad)
               0:       v = f;
               1:       v = FULL_Q14 - f;
               2:       v = -f;
               default: v = f - FULL_Q14;
            endcase
         end
         MODE_SAW: begin
            v = int'(((p << 15) + (64'd1 << (PB - 1))) >> PB) - FULL_Q14;
         end
         MODE_TAN: begin
            v = tangent_lookup(k);
         end
         default: begin
            v = 0;
         end
      endcase
      return v[SAMPLE_W-1:0];
   endfunction

   // predictions are queued when the req transaction is accepted
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         pending_samples.push_back(predict_sample(req_tdata, req_tuser));
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            $error("unexpected rsp transaction: sample %0d", $signed(rsp_tdata));
            fail_count++;
         end else begin
            want_sample = pending_samples.pop_front();
            if (rsp_tdata !== want_sample) begin
               $error("sample mismatch: expected %0d, actual %0d", want_sample,
                      $signed(rsp_tdata));
               fail_count++;
            end
         end
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         rsp_tready = 1'b1;
      end
   end

   // entered and left at a falling edge; valid is left high for the caller
   task automatic send_phase(input logic [PHASE_W-1:0] ph, input logic [MODE_W-1:0] md);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = ph;
      req_tuser  = md;
      do
         @(posedge clock);
      while (!req_tready);
      @(negedge clock);
   endtask

   task automatic test_directed_extremes();
      send_phase(16'h0000, MODE_SINE);
      send_phase(16'h4000, MODE_SINE);
      send_phase(16'hC000, MODE_SINE);
      send_phase(16'hFFFF, MODE_SINE);
      send_phase(16'h7FFF, MODE_SQUARE);
      send_phase(16'h8000, MODE_SQUARE);
      send_phase(16'h0000, MODE_SQUARE);
      send_phase(16'hFFFF, MODE_SQUARE);
      send_phase(16'h3FFF, MODE_TRI);
      send_phase(16'h4000, MODE_TRI);
      send_phase(16'hBFFF, MODE_TRI);
      send_phase(16'hC000, MODE_TRI);
      send_phase(16'h0000, MODE_SAW);
      send_phase(16'h0001, MODE_SAW);
      send_phase(16'h8000, MODE_SAW);
      send_phase(16'hFFFF, MODE_SAW);
      send_phase(16'h8000, MODE_TAN);   // pole at half cycle
      send_phase(16'h7FC0, MODE_TAN);
      send_phase(16'h8040, MODE_TAN);
      send_phase(16'hFFFF, MODE_TAN);
      send_phase(16'hFFFF, MODE_NULL5);
      send_phase(16'h0000, MODE_NULL6);
      send_phase(16'hAAAA, MODE_NULL7);
   endtask

   task automatic test_random_waveforms(input int count);
      logic [PHASE_W-1:0] ph;
      logic [MODE_W-1:0]  md;
      int                 pick;
      for (int i = 0; i < count; i++) begin
         md   = ($urandom_range(0, 9) < 8) ? MODE_W'($urandom_range(0, 4))
                                           : MODE_W'($urandom_range(5, 7));
         pick = $urandom_range(0, 9);
         if (pick < 7)
            ph = PHASE_W'($urandom);
         else if (pick < 9)
            ph = PHASE_W'({$urandom_range(0, 3), 14'd0} + $urandom_range(0, 128) - 64);
         else
            ph = PHASE_W'(17'h08000 + $urandom_range(0, 1024) - 512);
         send_phase(ph, md);
      end
   endtask

   task automatic test_sustained_rate(input int count);
      idle_enable = 1'b0;
      for (int i = 0; i < count; i++)
         send_phase(PHASE_W'($urandom), MODE_W'($urandom_range(0, 7)));
   endtask

   initial begin
      int wait_cycles;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      test_directed_extremes();
      test_random_waveforms(600);
      test_sustained_rate(200);
      req_tvalid  = 1'b0;
      wait_cycles = 0;
      while (pending_samples.size() != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      if (pending_samples.size() != 0) begin
         $error("%0d expected samples never arrived", pending_samples.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
